@@ rtl/ssf_pkg.sv @@
// shared types, constants and helper functions for the seven-segment screen formatter
`timescale 1ns / 1ps

package ssf_pkg;

    // segment codes, active low, bit 7 is the decimal point
    localparam logic [7:0] SEG_BLANK   = 8'hFF;
    localparam logic [7:0] SEG_DP_MASK = 8'h7F;
    localparam logic [7:0] SEG_H       = 8'h89;
    localparam logic [7:0] SEG_C       = 8'hC6;
    localparam logic [7:0] SEG_U       = 8'hC1;
    localparam logic [7:0] SEG_F       = 8'h8E;
    localparam logic [7:0] SEG_P       = 8'h8C;

    localparam int unsigned VALUE_W = 20;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned THOU_W  = 11;   // value / 1000 is at most 1048
    localparam int unsigned REM_W   = 10;   // value % 1000 is at most 999
    localparam int unsigned POS_N   = 8;

    // floor(v / 1000) = (v * RECIP_1000) >> RECIP_1000_SH for any 20-bit v
    localparam logic [20:0] RECIP_1000    = 21'd1073742;
    localparam int unsigned RECIP_1000_SH = 30;
    localparam logic [20:0] THOUSAND      = 21'd1000;

    // small dividers for values below 1049
    localparam logic [16:0] RECIP_10     = 17'd52429;
    localparam int unsigned RECIP_10_SH  = 19;
    localparam logic [10:0] RECIP_100    = 11'd1311;
    localparam int unsigned RECIP_100_SH = 17;

    typedef enum logic [FUNC_W-1:0] {
        SCR_TEMP      = 3'd0,
        SCR_VOLT      = 3'd1,
        SCR_FREQ      = 3'd2,
        SCR_HOLD_TEMP = 3'd3,
        SCR_HOLD_VOLT = 3'd4,
        SCR_HOLD_FREQ = 3'd5,
        SCR_PARAM     = 3'd6,
        SCR_BLANK     = 3'd7
    } t_screen;

    typedef logic [POS_N-1:0][7:0] t_seg_row;

    // result of the thousands split: two narrow halves and the blanking compares
    typedef struct packed {
        logic [THOU_W-1:0] thou;
        logic [REM_W-1:0]  rem;
        logic [5:1]        ge_pow10;   // bit k: value >= 10^k
    } t_split;

    typedef struct packed {
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } t_digits3;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    // three low decimal digits of x (x < 1049); the hundreds digit wraps at ten
    function automatic t_digits3 digits3(input logic [THOU_W-1:0] x);
        logic [27:0] p10;
        logic [21:0] p100;
        logic [6:0]  t;
        logic [3:0]  u;
        logic [10:0] t_x10;
        logic [6:0]  u_x10;
        t_digits3    d;
        p10   = 28'(x) * 28'(RECIP_10);
        p100  = 22'(x) * 22'(RECIP_100);
        t     = p10[RECIP_10_SH +: 7];
        u     = p100[RECIP_100_SH +: 4];
        t_x10 = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
        u_x10 = {u, 3'b000} - {u, 1'b0} + {2'b00, u, 1'b0} + {2'b00, u, 1'b0};
        d.d0  = 4'(x - t_x10);
        d.d1  = 4'(t - u_x10);
        d.d2  = (u >= 4'd10) ? 4'(u - 4'd10) : u;
        return d;
    endfunction

endpackage

@@ rtl/seven_segment_screen_formatter_core.sv @@
// top level: three-register pipeline turning a screen request into eight segment bytes
// a request passes the input, split and result registers before it shows on o_valid
// throughput: one request per cycle; each stage moves on when the stage after it
//   is empty or is moving on, so o_stall rises only with all three stages full and held
// reset: synchronous active-low i_rst_n empties every stage; data registers are not reset
`timescale 1ns / 1ps

module seven_segment_screen_formatter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request side
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ssf_pkg::FUNC_W-1:0]  i_func,
    input  logic [ssf_pkg::VALUE_W-1:0] i_value,
    // result side
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_seg_pos0,
    output logic [7:0]                  o_seg_pos1,
    output logic [7:0]                  o_seg_pos2,
    output logic [7:0]                  o_seg_pos3,
    output logic [7:0]                  o_seg_pos4,
    output logic [7:0]                  o_seg_pos5,
    output logic [7:0]                  o_seg_pos6,
    output logic [7:0]                  o_seg_pos7
);

    // stage 1: input register
    logic                        r_s1_valid;
    ssf_pkg::t_screen            r_s1_func;
    logic [ssf_pkg::VALUE_W-1:0] r_s1_value;

    // stage 2: thousands split and blanking flags
    logic                        r_s2_valid;
    ssf_pkg::t_screen            r_s2_func;
    ssf_pkg::t_split             r_s2_split;

    // stage 3: result register
    logic                        r_o_valid;
    ssf_pkg::t_seg_row           r_o_seg;

    ssf_pkg::t_split             w_split;
    ssf_pkg::t_seg_row           w_seg;

    logic w_out_en;
    logic w_s2_en;
    logic w_s1_en;
    logic w_in_take;

    // a stage loads when it is empty or its content moves on this cycle
    assign w_out_en  = !r_o_valid || !i_stall;
    assign w_s2_en   = !r_s2_valid || w_out_en;
    assign w_s1_en   = !r_s1_valid || w_s2_en;
    assign o_stall   = !w_s1_en;
    assign w_in_take = i_valid && w_s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_en) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    // payload moves only with a valid request, so a held result never changes
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_func  <= ssf_pkg::t_screen'(i_func);
            r_s1_value <= i_value;
        end
        if (w_s2_en && r_s1_valid) begin
            r_s2_func  <= r_s1_func;
            r_s2_split <= w_split;
        end
        if (w_out_en && r_s2_valid) begin
            r_o_seg <= w_seg;
        end
    end

    // value -> thousands, remainder, compares against powers of ten
    ssf_split u_split (
        .i_value (r_s1_value),
        .o_split (w_split)
    );

    // digits and per-screen layout
    ssf_format u_format (
        .i_screen (r_s2_func),
        .i_split  (r_s2_split),
        .o_seg    (w_seg)
    );

    assign o_valid    = r_o_valid;
    assign o_seg_pos0 = r_o_seg[0];
    assign o_seg_pos1 = r_o_seg[1];
    assign o_seg_pos2 = r_o_seg[2];
    assign o_seg_pos3 = r_o_seg[3];
    assign o_seg_pos4 = r_o_seg[4];
    assign o_seg_pos5 = r_o_seg[5];
    assign o_seg_pos6 = r_o_seg[6];
    assign o_seg_pos7 = r_o_seg[7];

    // back-pressure only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s2_valid && r_o_valid))
        else $error("stall raised with an empty stage");

    // a taken request always lands in stage 1
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> r_s1_valid)
        else $error("accepted request lost at stage 1");

    // a held stage 2 entry is not dropped while the result side stalls
    a_s2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_out_en) |=> r_s2_valid)
        else $error("stage 2 entry dropped under stall");

    // any screen with a prefix letter always shows a rightmost digit
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_seg_pos0 != ssf_pkg::SEG_BLANK)) |-> (o_seg_pos7 != ssf_pkg::SEG_BLANK))
        else $error("rightmost digit blank on a live screen");

endmodule

@@ rtl/ssf_split.sv @@
// first stage logic: splits the value into thousands and remainder, and blanking compares
`timescale 1ns / 1ps

module ssf_split (
    input  logic [ssf_pkg::VALUE_W-1:0] i_value,
    output ssf_pkg::t_split             o_split
);

    logic [40:0] w_prod;
    logic [10:0] w_q_est;
    logic [20:0] w_q_x1000;
    logic [20:0] w_rem_est;
    logic        w_fix;

    // reciprocal multiply, then one compare-subtract correction
    assign w_prod    = 41'(i_value) * 41'(ssf_pkg::RECIP_1000);
    assign w_q_est   = w_prod[ssf_pkg::RECIP_1000_SH +: ssf_pkg::THOU_W];
    assign w_q_x1000 = {w_q_est, 10'b0} - {6'b0, w_q_est, 4'b0} - {7'b0, w_q_est, 3'b0};
    assign w_rem_est = {1'b0, i_value} - w_q_x1000;
    assign w_fix     = (w_rem_est >= ssf_pkg::THOUSAND);

    always_comb begin
        o_split.thou = w_fix ? (w_q_est + 11'd1) : w_q_est;
        o_split.rem  = w_fix ? 10'(w_rem_est - ssf_pkg::THOUSAND) : w_rem_est[9:0];
        o_split.ge_pow10[1] = (i_value >= 20'd10);
        o_split.ge_pow10[2] = (i_value >= 20'd100);
        o_split.ge_pow10[3] = (i_value >= 20'd1000);
        o_split.ge_pow10[4] = (i_value >= 20'd10000);
        o_split.ge_pow10[5] = (i_value >= 20'd100000);
    end

endmodule

@@ rtl/ssf_format.sv @@
// second stage logic: decimal digits and screen layout into segment bytes
`timescale 1ns / 1ps

module ssf_format (
    input  ssf_pkg::t_screen  i_screen,
    input  ssf_pkg::t_split   i_split,
    output ssf_pkg::t_seg_row o_seg
);

    ssf_pkg::t_digits3 w_lo;
    ssf_pkg::t_digits3 w_hi;
    logic [7:0]        w_dig [6];
    logic [7:0]        w_tmp [4];
    logic [7:0]        w_tnt [2];
    logic [7:0]        w_frq [6];

    assign w_lo = ssf_pkg::digits3({1'b0, i_split.rem});
    assign w_hi = ssf_pkg::digits3(i_split.thou);

    assign w_dig[0] = ssf_pkg::seg_of(w_lo.d0);
    assign w_dig[1] = ssf_pkg::seg_of(w_lo.d1);
    assign w_dig[2] = ssf_pkg::seg_of(w_lo.d2);
    assign w_dig[3] = ssf_pkg::seg_of(w_hi.d0);
    assign w_dig[4] = ssf_pkg::seg_of(w_hi.d1);
    assign w_dig[5] = ssf_pkg::seg_of(w_hi.d2);

    // xx.xx
    assign w_tmp[0] = i_split.ge_pow10[3] ? w_dig[3] : ssf_pkg::SEG_BLANK;
    assign w_tmp[1] = w_dig[2] & ssf_pkg::SEG_DP_MASK;
    assign w_tmp[2] = w_dig[1];
    assign w_tmp[3] = w_dig[0];

    // x.x
    assign w_tnt[0] = w_dig[1] & ssf_pkg::SEG_DP_MASK;
    assign w_tnt[1] = w_dig[0];

    // six digits, leading zeros blank
    assign w_frq[0] = i_split.ge_pow10[5] ? w_dig[5] : ssf_pkg::SEG_BLANK;
    assign w_frq[1] = i_split.ge_pow10[4] ? w_dig[4] : ssf_pkg::SEG_BLANK;
    assign w_frq[2] = i_split.ge_pow10[3] ? w_dig[3] : ssf_pkg::SEG_BLANK;
    assign w_frq[3] = i_split.ge_pow10[2] ? w_dig[2] : ssf_pkg::SEG_BLANK;
    assign w_frq[4] = i_split.ge_pow10[1] ? w_dig[1] : ssf_pkg::SEG_BLANK;
    assign w_frq[5] = w_dig[0];

    always_comb begin
        o_seg = {ssf_pkg::POS_N{ssf_pkg::SEG_BLANK}};
        unique case (i_screen)
            ssf_pkg::SCR_TEMP: begin
                o_seg[0] = ssf_pkg::SEG_C;
                o_seg[4] = w_tmp[0];
                o_seg[5] = w_tmp[1];
                o_seg[6] = w_tmp[2];
                o_seg[7] = w_tmp[3];
            end
            ssf_pkg::SCR_HOLD_TEMP: begin
                o_seg[0] = ssf_pkg::SEG_H;
                o_seg[1] = ssf_pkg::SEG_C;
                o_seg[4] = w_tmp[0];
                o_seg[5] = w_tmp[1];
                o_seg[6] = w_tmp[2];
                o_seg[7] = w_tmp[3];
            end
            ssf_pkg::SCR_VOLT: begin
                o_seg[0] = ssf_pkg::SEG_U;
                o_seg[6] = w_tnt[0];
                o_seg[7] = w_tnt[1];
            end
            ssf_pkg::SCR_HOLD_VOLT: begin
                o_seg[0] = ssf_pkg::SEG_H;
                o_seg[1] = ssf_pkg::SEG_U;
                o_seg[6] = w_tnt[0];
                o_seg[7] = w_tnt[1];
            end
            ssf_pkg::SCR_PARAM: begin
                o_seg[0] = ssf_pkg::SEG_P;
                o_seg[6] = w_tnt[0];
                o_seg[7] = w_tnt[1];
            end
            ssf_pkg::SCR_FREQ: begin
                o_seg[0] = ssf_pkg::SEG_F;
                for (int i = 0; i < 6; i++) begin
                    o_seg[i+2] = w_frq[i];
                end
            end
            ssf_pkg::SCR_HOLD_FREQ: begin
                o_seg[0] = ssf_pkg::SEG_H;
                o_seg[1] = ssf_pkg::SEG_F;
                for (int i = 0; i < 6; i++) begin
                    o_seg[i+2] = w_frq[i];
                end
            end
            ssf_pkg::SCR_BLANK: begin
                o_seg = {ssf_pkg::POS_N{ssf_pkg::SEG_BLANK}};
            end
            default: begin
                o_seg = {ssf_pkg::POS_N{ssf_pkg::SEG_BLANK}};
            end
        endcase
    end

endmodule
